// ===== rtl/wtp_pkg.sv =====
package wtp_pkg;

    // field widths fixed by the interface
    localparam int WEIGHT_W  = 16;
    localparam int GRAIN_W   = 14;
    localparam int CHOSEN_W  = 3;
    localparam int REG_COUNT = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 5;
    localparam int APB_W     = 32;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    // static selection info derived from the weight registers
    typedef struct packed {
        logic [CHOSEN_W-1:0] last_nz;  // highest transform with a nonzero weight
        logic                none;     // all active weights are zero
    } t_sel_ctl;

endpackage

// ===== rtl/wtp_cfg.sv =====
module wtp_cfg #(
    parameter int NUM_WEIGHTS = 8,
    parameter int SUM_W       = 19
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wtp_pkg::ADDR_W-1:0]  paddr,
    input  logic [wtp_pkg::APB_W-1:0]   pwdata,
    output logic [wtp_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output logic [SUM_W-1:0]            o_prefix [NUM_WEIGHTS],
    output wtp_pkg::t_sel_ctl           o_ctl
);
    import wtp_pkg::*;

    logic [WEIGHT_W-1:0] r_weight [REG_COUNT];
    logic [WEIGHT_W-1:0] n_weight [REG_COUNT];
    logic [SUM_W-1:0]    r_prefix [NUM_WEIGHTS];
    logic [SUM_W-1:0]    n_prefix [NUM_WEIGHTS];
    t_sel_ctl            r_ctl;
    t_sel_ctl            n_ctl;
    logic [SUM_W-1:0]    acc;
    logic [IDX_W-1:0]    wr_idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_idx = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // register read
    assign prdata = {{(APB_W-WEIGHT_W){1'b0}}, r_weight[wr_idx]};

    // weights after this cycle's write
    always_comb begin
        for (int k = 0; k < REG_COUNT; k++) begin
            n_weight[k] = r_weight[k];
        end
        if (wr_en) begin
            n_weight[wr_idx] = pwdata[WEIGHT_W-1:0];
        end
    end

    // running prefix sums and highest nonzero weight
    always_comb begin
        acc           = '0;
        n_ctl.last_nz = '0;
        for (int j = 0; j < NUM_WEIGHTS; j++) begin
            acc         = acc + SUM_W'(n_weight[j]);
            n_prefix[j] = acc;
            if (n_weight[j] != '0) begin
                n_ctl.last_nz = CHOSEN_W'(j);
            end
        end
        n_ctl.none = (acc == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_weight[k] <= '0;
            end
            for (int j = 0; j < NUM_WEIGHTS; j++) begin
                r_prefix[j] <= '0;
            end
            r_ctl.last_nz <= '0;
            r_ctl.none    <= 1'b1;
        end else begin
            r_weight <= n_weight;
            r_prefix <= n_prefix;
            r_ctl    <= n_ctl;
        end
    end

    assign o_prefix = r_prefix;
    assign o_ctl    = r_ctl;

endmodule

// ===== rtl/weighted_transform_picker.sv =====
// Weighted transform picker. Each 14-bit grain index beat on the slave stream
// yields one beat on the master stream naming the transform j, the smallest
// for which grain * (sum of weights) < TABLE_SIZE * (weights 0..j); a zero
// weight is never picked, a grain at or above TABLE_SIZE saturates to the
// highest nonzero-weight transform, and with all weights zero no_weight (tuser)
// is 1 and chosen is 0. The block takes one beat per clock unless the master
// stream back-pressures. The grain lands in an input register. The
// grain-times-sum product, the prefix compares and the priority pick then run
// as one combinational pass into the result register, which drives the master
// stream. Stalls come only from master back-pressure.
// Weights are written over the APB port at byte address 4*i. The prefix sums
// are rebuilt in the same edge as the write, so beats may follow right after
// configuration; write weights only while no beat is in flight.
module weighted_transform_picker #(
    parameter int TABLE_SIZE  = 16384,
    parameter int NUM_WEIGHTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wtp_pkg::ADDR_W-1:0]    paddr,
    input  logic [wtp_pkg::APB_W-1:0]     pwdata,
    output logic [wtp_pkg::APB_W-1:0]     prdata,
    output logic                          pready,
    // slave stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [wtp_pkg::S_DATA_W-1:0]  i_s_tdata,   // [13:0] grain_index
    // master stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [wtp_pkg::M_DATA_W-1:0]  o_m_tdata,   // [2:0] chosen
    output logic [0:0]                    o_m_tuser    // [0] no_weight
);
    import wtp_pkg::*;

    localparam int SUM_W = WEIGHT_W + $clog2(NUM_WEIGHTS);
    localparam int TS_W  = $clog2(TABLE_SIZE + 1);
    localparam int LHS_W = GRAIN_W + SUM_W;
    localparam int CMP_W = SUM_W + ((TS_W > GRAIN_W) ? TS_W : GRAIN_W);

    logic [SUM_W-1:0]    prefix [NUM_WEIGHTS];
    t_sel_ctl            ctl;

    logic                r_v1, r_v2;
    logic                rdy1, rdy2;
    logic [GRAIN_W-1:0]  r_grain;
    logic [LHS_W-1:0]    lhs;
    logic [CHOSEN_W-1:0] r_chosen;
    logic                r_none;
    logic [CHOSEN_W-1:0] n_chosen;
    logic [NUM_WEIGHTS-1:0] hit;

    wtp_cfg #(
        .NUM_WEIGHTS (NUM_WEIGHTS),
        .SUM_W       (SUM_W)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_prefix (prefix),
        .o_ctl    (ctl)
    );

    // per-stage ready, bubbles collapse
    assign rdy2       = !r_v2 || i_m_tready;
    assign rdy1       = !r_v1 || rdy2;
    assign o_s_tready = rdy1;

    // grain times total weight
    assign lhs = LHS_W'(r_grain) * LHS_W'(prefix[NUM_WEIGHTS-1]);

    // threshold compare and priority pick
    always_comb begin
        for (int j = 0; j < NUM_WEIGHTS; j++) begin
            hit[j] = CMP_W'(lhs) < (CMP_W'(TABLE_SIZE) * CMP_W'(prefix[j]));
        end
        n_chosen = ctl.last_nz;
        for (int j = NUM_WEIGHTS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                n_chosen = CHOSEN_W'(j);
            end
        end
        if (ctl.none) begin
            n_chosen = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_s_tvalid) begin
            r_grain <= i_s_tdata[GRAIN_W-1:0];
        end
        if (rdy2 && r_v1) begin
            r_chosen <= n_chosen;
            r_none   <= ctl.none;
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = {{(M_DATA_W-CHOSEN_W){1'b0}}, r_chosen};
    assign o_m_tuser  = r_none;

endmodule

// ===== rtl/wtp_checker.sv =====
module wtp_checker #(
    parameter int NUM_WEIGHTS = 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [wtp_pkg::M_DATA_W-1:0]  o_m_tdata,
    input logic [0:0]                    o_m_tuser
);
    import wtp_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat right after reset");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result beat changed");

    // no weight flag forces transform zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[CHOSEN_W-1:0] == '0)
        else $error("chosen nonzero with no weight");

    // chosen stays among active transforms, padding is zero
    a_chosen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[CHOSEN_W-1:0]) < NUM_WEIGHTS)
            && (o_m_tdata[M_DATA_W-1:CHOSEN_W] == '0))
        else $error("chosen out of range");

endmodule

bind weighted_transform_picker wtp_checker #(
    .NUM_WEIGHTS (NUM_WEIGHTS)
) u_wtp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== tb/weighted_transform_picker_tb.sv =====
`timescale 1ns / 100ps

module weighted_transform_picker_tb;

    import wtp_pkg::*;

    localparam int GRAIN_RANGE = 16384;
    localparam int N_XFORM     = 8;
    localparam int MAX_WAIT    = 16;

    // one result beat: transform index plus the empty-weight flag
    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic                no_weight;
    } t_pick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_W-1:0]      pwdata = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;   // [13:0] grain_index
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;        // [2:0] chosen
    logic [0:0]            o_m_tuser;        // [0] no_weight

    weighted_transform_picker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // shadow copy of the weight registers
    logic [WEIGHT_W-1:0] weight_shadow [N_XFORM];
    logic [WEIGHT_W-1:0] next_weights [N_XFORM];

    logic [GRAIN_W-1:0] grain_backlog [$];
    t_pick              expected_picks [$];
    int                 grains_unaccepted = 0;

    int mismatches = 0;
    int beats_checked = 0;
    int empty_weight_beats = 0;
    int weight_settings = 0;
    int pick_count [N_XFORM];

    int  send_gap = 0;
    int  stall_left = 0;
    int  rx_draw;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop in case the pipeline hangs
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    // smallest j with grain * sum < GRAIN_RANGE * prefix(j); saturate to top nonzero
    function automatic t_pick pick_transform(input logic [GRAIN_W-1:0] grain);
        t_pick           res;
        longint unsigned total;
        longint unsigned prefix;
        longint unsigned scaled;
        int              top_nz;
        bit              found;
        total  = 0;
        prefix = 0;
        top_nz = 0;
        found  = 1'b0;
        res    = '0;
        for (int j = 0; j < N_XFORM; j++) begin
            total += weight_shadow[j];
            if (weight_shadow[j] != 0)
                top_nz = j;
        end
        if (total == 0) begin
            res.no_weight = 1'b1;
            return res;
        end
        scaled = longint'(grain) * total;
        for (int j = 0; j < N_XFORM; j++) begin
            prefix += weight_shadow[j];
            if (!found && scaled < longint'(GRAIN_RANGE) * prefix) begin
                res.chosen = CHOSEN_W'(j);
                found = 1'b1;
            end
        end
        if (!found)
            res.chosen = CHOSEN_W'(top_nz);
        return res;
    endfunction

    function automatic logic [WEIGHT_W-1:0] draw_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return WEIGHT_W'($urandom_range(1, 16));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    // grain just around the step from transform j to transform j+1, j drawn at random
    function automatic logic [GRAIN_W-1:0] draw_edge_grain();
        longint unsigned total;
        longint unsigned prefix;
        longint          step;
        longint          g;
        int              upto;
        total  = 0;
        prefix = 0;
        upto   = $urandom_range(0, N_XFORM - 1);
        for (int j = 0; j < N_XFORM; j++) begin
            total += weight_shadow[j];
            if (j <= upto)
                prefix += weight_shadow[j];
        end
        if (total == 0)
            return GRAIN_W'($urandom);
        step = (longint'(GRAIN_RANGE) * prefix + total - 1) / total;
        g = step - 1 + $urandom_range(0, 2);
        if (g < 0)
            g = 0;
        if (g > GRAIN_RANGE - 1)
            g = GRAIN_RANGE - 1;
        return GRAIN_W'(g);
    endfunction

    task automatic queue_grain(input logic [GRAIN_W-1:0] grain);
        grain_backlog.push_back(grain);
        grains_unaccepted++;
    endtask

    // wait until every grain is taken and every result beat is checked, then idle
    task automatic drain();
        while (grains_unaccepted != 0 || expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_write(input int idx, input logic [WEIGHT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= APB_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        weight_shadow[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input int idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[WEIGHT_W-1:0] !== weight_shadow[idx])
            report_mismatch($sformatf("weight_%0d readback", idx),
                            weight_shadow[idx], prdata[WEIGHT_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // load next_weights into the block and read every register back
    task automatic load_weights();
        for (int j = 0; j < N_XFORM; j++)
            apb_write(j, next_weights[j]);
        for (int j = 0; j < N_XFORM; j++)
            apb_read_check(j);
        weight_settings++;
    endtask

    // grain beat sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_picks.push_back(pick_transform(i_s_tdata[GRAIN_W-1:0]));
                grains_unaccepted--;
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the beat until it is taken
            end else if (send_gap != 0) begin
                i_s_tvalid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (grain_backlog.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= S_DATA_W'(grain_backlog.pop_front());
                send_gap   <= tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result beat checker with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            if (expected_picks.size() == 0) begin
                report_mismatch("result beat with nothing pending", -1, o_m_tdata[CHOSEN_W-1:0]);
            end else begin
                t_pick want;
                want = expected_picks.pop_front();
                if (o_m_tdata[CHOSEN_W-1:0] !== want.chosen)
                    report_mismatch("chosen", want.chosen, o_m_tdata[CHOSEN_W-1:0]);
                if (o_m_tuser[0] !== want.no_weight)
                    report_mismatch("no_weight", want.no_weight, o_m_tuser[0]);
            end
            beats_checked++;
            if (o_m_tuser[0] === 1'b1)
                empty_weight_beats++;
            else
                pick_count[o_m_tdata[CHOSEN_W-1:0]]++;
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            rx_draw = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left <= rx_draw;
            i_m_tready <= (rx_draw == 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        for (int j = 0; j < N_XFORM; j++) begin
            weight_shadow[j] = '0;
            pick_count[j] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // weights still at reset: every beat flags no weight
        queue_grain('0);
        queue_grain('1);
        queue_grain(14'h2AAA);
        drain();

        // equal full weights: steps every 2048 grains
        next_weights = '{default: '1};
        load_weights();
        foreach (next_weights[j]) begin end
        queue_grain(14'd0);
        queue_grain(14'd2047);
        queue_grain(14'd2048);
        queue_grain(14'd14335);
        queue_grain(14'd14336);
        queue_grain(14'd16383);
        drain();

        // only the top transform has weight, and the smallest one
        next_weights = '{default: '0};
        next_weights[N_XFORM-1] = 16'd1;
        load_weights();
        queue_grain('0);
        queue_grain('1);
        drain();

        // only the bottom transform has weight
        next_weights = '{default: '0};
        next_weights[0] = '1;
        load_weights();
        queue_grain('0);
        queue_grain('1);
        drain();

        // sparse mix with zero weights in between
        next_weights = '{16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd0};
        load_weights();
        queue_grain(14'd0);
        queue_grain(14'd1);
        queue_grain(14'd8191);
        queue_grain(14'd16383);
        drain();

        // all weights written back to zero
        next_weights = '{default: '0};
        load_weights();
        queue_grain(14'd5);
        queue_grain(14'h3FFE);
        drain();

        // random weight sets, grains mostly uniform, some on the steps
        for (int phase = 0; phase < 8; phase++) begin
            foreach (next_weights[j])
                next_weights[j] = draw_weight();
            load_weights();
            for (int k = 0; k < 125; k++) begin
                case ($urandom_range(0, 7))
                    0, 1:    queue_grain(draw_edge_grain());
                    2:       queue_grain($urandom_range(0, 1) ? '1
                                         : GRAIN_W'($urandom_range(0, 3)));
                    default: queue_grain(GRAIN_W'($urandom));
                endcase
            end
            drain();
        end

        $display("checked %0d result beats over %0d weight settings, %0d with no weight set",
                 beats_checked, weight_settings, empty_weight_beats);
        $display("picks per transform: %0d %0d %0d %0d %0d %0d %0d %0d",
                 pick_count[0], pick_count[1], pick_count[2], pick_count[3],
                 pick_count[4], pick_count[5], pick_count[6], pick_count[7]);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
